// File: rtl/core/ubf_pkg.sv
package ubf_pkg;

  localparam int unsigned CMD_W         = 3;
  localparam int unsigned UID_W         = 32;
  localparam int unsigned PROTO_W       = 2;
  localparam int unsigned RIDX_W        = 8;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned VERDICT_W     = 2;
  localparam int unsigned ENTRY_COUNT_W = 9;

  localparam logic [CMD_W-1:0] CMD_PKT_CHECK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PROC_CHECK = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [PROTO_W-1:0] PROTO_IPV4 = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_IPV6 = 2'd1;

  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT     = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DROP_ICMP4 = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_DROP_ICMP6 = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DROP       = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [UID_W-1:0]   subject_uid;
    logic               has_owner;
    logic [PROTO_W-1:0] protocol_kind;
    logic [RIDX_W-1:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     blocked;
    logic [VERDICT_W-1:0]     verdict;
    logic [UID_W-1:0]         entry_value;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_cmd_t;

endpackage

// File: rtl/core/ubf_chan_if.sv
interface ubf_in_if;
  logic             valid;
  logic             ready;
  ubf_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ubf_out_if;
  logic               valid;
  logic               ready;
  ubf_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/uid_blocklist_filter_table.sv
// Flow: clear, unknown commands, exempt checks, adds when full and out-of-range reads go
//   straight to ST_DONE; an in-range read passes ST_RD_ISSUE and ST_RD_WAIT; checks, add
//   and remove scan one entry per cycle in ST_SCAN, up to the count. Remove shifts each
//   later entry down (ST_SHIFT_RD, ST_SHIFT_WR) on the single memory port; words go one at a time.
// Reset (synchronous, rst_n low): count, enable and handshake state cleared;
//   table contents are not cleared, entries at or past the count are never read.
module uid_blocklist_filter_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  ubf_in_if.sink    in_ch,
  ubf_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

  ubf_pkg::mem_cmd_t         mem_cmd;
  logic [ADDR_W-1:0]         mem_addr;
  logic [ubf_pkg::UID_W-1:0] mem_wdata;
  logic [ubf_pkg::UID_W-1:0] mem_rdata;

  ubf_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  ubf_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk       (clk),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule

// File: rtl/core/ubf_mem.sv
module ubf_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8
) (
  input  logic                      clk,
  input  ubf_pkg::mem_cmd_t         mem_cmd,
  input  logic [ADDR_W-1:0]         mem_addr,
  input  logic [ubf_pkg::UID_W-1:0] mem_wdata,
  output logic [ubf_pkg::UID_W-1:0] mem_rdata
);

  logic [ubf_pkg::UID_W-1:0] store_r [DEPTH];
  logic [ubf_pkg::UID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_cmd.we) begin
      store_r[mem_addr] <= mem_wdata;
    end
    if (mem_cmd.re) begin
      rdata_r <= store_r[mem_addr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

// File: rtl/core/ubf_ctrl.sv
module ubf_ctrl #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned ADDR_W      = 8,
  parameter int unsigned CNT_W       = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ubf_in_if.sink                    in_ch,
  ubf_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  output ubf_pkg::mem_cmd_t         mem_cmd,
  output logic [ADDR_W-1:0]         mem_addr,
  output logic [ubf_pkg::UID_W-1:0] mem_wdata,
  input  logic [ubf_pkg::UID_W-1:0] mem_rdata
);

  localparam int unsigned CMP_W = (CNT_W > ubf_pkg::RIDX_W) ? CNT_W : ubf_pkg::RIDX_W;
  localparam int unsigned OUT_W = (CNT_W > ubf_pkg::ENTRY_COUNT_W) ? CNT_W
                                                                   : ubf_pkg::ENTRY_COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  state_t                         state_r;
  logic [CNT_W-1:0]               count_r;
  logic                           en_r;
  logic [ubf_pkg::CMD_W-1:0]      cmd_r;
  logic [ubf_pkg::UID_W-1:0]      uid_r;
  logic [ubf_pkg::PROTO_W-1:0]    proto_r;
  logic [CMP_W-1:0]               ridx_r;
  logic [CNT_W-1:0]               rd_ptr_r;
  logic [CNT_W-1:0]               cmp_ptr_r;
  logic [CNT_W-1:0]               pos_r;
  logic                           rvld_r;
  logic [ubf_pkg::STATUS_W-1:0]   status_r;
  logic                           blocked_r;
  logic [ubf_pkg::VERDICT_W-1:0]  verdict_r;
  logic [ubf_pkg::UID_W-1:0]      entry_r;
  logic                           out_valid_r;
  ubf_pkg::out_word_t             out_data_r;

  logic             hit;
  logic             issue;
  logic             miss_done;
  logic             full;
  logic [CNT_W-1:0] pos_inc;
  logic [CMP_W-1:0] in_ridx;
  logic [OUT_W-1:0] count_ext;

  assign hit       = rvld_r && (mem_rdata == uid_r);
  assign issue     = (rd_ptr_r < count_r) && !hit;
  assign miss_done = !hit && !rvld_r && (rd_ptr_r >= count_r);
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));
  assign pos_inc   = pos_r + CNT_W'(1);
  assign in_ridx   = CMP_W'(in_ch.data.read_index);
  assign count_ext = OUT_W'(count_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    mem_cmd   = '0;
    mem_addr  = '0;
    mem_wdata = uid_r;
    case (state_r)
      ST_SCAN: begin
        if (issue) begin
          mem_cmd.re = 1'b1;
          mem_addr   = rd_ptr_r[ADDR_W-1:0];
        end else if (miss_done && cmd_r == ubf_pkg::CMD_ADD) begin
          mem_cmd.we = 1'b1;
          mem_addr   = count_r[ADDR_W-1:0];
        end
      end
      ST_SHIFT_RD: begin
        if (pos_inc < count_r) begin
          mem_cmd.re = 1'b1;
          mem_addr   = pos_inc[ADDR_W-1:0];
        end
      end
      ST_SHIFT_WR: begin
        mem_cmd.we = 1'b1;
        mem_addr   = pos_r[ADDR_W-1:0];
        mem_wdata  = mem_rdata;
      end
      ST_RD_ISSUE: begin
        mem_cmd.re = 1'b1;
        mem_addr   = ridx_r[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      en_r        <= 1'b0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            cmd_r     <= in_ch.data.cmd;
            uid_r     <= in_ch.data.subject_uid;
            proto_r   <= in_ch.data.protocol_kind;
            ridx_r    <= in_ridx;
            status_r  <= ubf_pkg::STATUS_OK;
            blocked_r <= 1'b0;
            verdict_r <= ubf_pkg::VERDICT_ACCEPT;
            entry_r   <= '0;
            rd_ptr_r  <= '0;
            rvld_r    <= 1'b0;
            state_r   <= ST_DONE;
            case (in_ch.data.cmd)
              ubf_pkg::CMD_PKT_CHECK: begin
                if (en_r && in_ch.data.has_owner && in_ch.data.subject_uid != '0 &&
                    count_r != '0) begin
                  state_r <= ST_SCAN;
                end
              end
              ubf_pkg::CMD_PROC_CHECK: begin
                if (en_r && count_r != '0) begin
                  state_r <= ST_SCAN;
                end
              end
              ubf_pkg::CMD_ADD: begin
                if (full) begin
                  status_r <= ubf_pkg::STATUS_FULL;
                end else begin
                  state_r <= ST_SCAN;
                end
              end
              ubf_pkg::CMD_REMOVE: begin
                state_r <= ST_SCAN;
              end
              ubf_pkg::CMD_CLEAR: begin
                count_r <= '0;
              end
              ubf_pkg::CMD_READ: begin
                if (in_ridx < CMP_W'(count_r)) begin
                  state_r <= ST_RD_ISSUE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          rvld_r    <= issue;
          cmp_ptr_r <= rd_ptr_r;
          if (issue) begin
            rd_ptr_r <= rd_ptr_r + CNT_W'(1);
          end
          if (hit) begin
            rvld_r <= 1'b0;
            case (cmd_r)
              ubf_pkg::CMD_PKT_CHECK: begin
                blocked_r <= 1'b1;
                case (proto_r)
                  ubf_pkg::PROTO_IPV4: verdict_r <= ubf_pkg::VERDICT_DROP_ICMP4;
                  ubf_pkg::PROTO_IPV6: verdict_r <= ubf_pkg::VERDICT_DROP_ICMP6;
                  default:             verdict_r <= ubf_pkg::VERDICT_DROP;
                endcase
                state_r <= ST_DONE;
              end
              ubf_pkg::CMD_PROC_CHECK: begin
                blocked_r <= 1'b1;
                state_r   <= ST_DONE;
              end
              ubf_pkg::CMD_REMOVE: begin
                pos_r   <= cmp_ptr_r;
                state_r <= ST_SHIFT_RD;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end else if (miss_done) begin
            if (cmd_r == ubf_pkg::CMD_ADD) begin
              count_r <= count_r + CNT_W'(1);
            end else if (cmd_r == ubf_pkg::CMD_REMOVE) begin
              status_r <= ubf_pkg::STATUS_NOT_FOUND;
            end
            state_r <= ST_DONE;
          end
        end
        ST_SHIFT_RD: begin
          if (pos_inc < count_r) begin
            state_r <= ST_SHIFT_WR;
          end else begin
            count_r <= count_r - CNT_W'(1);
            state_r <= ST_DONE;
          end
        end
        ST_SHIFT_WR: begin
          pos_r   <= pos_inc;
          state_r <= ST_SHIFT_RD;
        end
        ST_RD_ISSUE: begin
          state_r <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          entry_r <= mem_rdata;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.status       <= status_r;
            out_data_r.blocked      <= blocked_r;
            out_data_r.verdict      <= verdict_r;
            out_data_r.entry_value  <= entry_r;
            out_data_r.entry_count  <= count_ext[ubf_pkg::ENTRY_COUNT_W-1:0];
            state_r                 <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_cmd.re && mem_cmd.we))
    else $error("read and write in the same cycle");

  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT_WR) |-> $past(state_r == ST_SHIFT_RD))
    else $error("shift write without preceding read");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word loaded outside done state");
`endif

endmodule

// File: verif/uid_blocklist_checker.sv
module uid_blocklist_checker #(
  parameter int unsigned DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  ubf_in_if    in_ch,
  ubf_out_if   out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   fail_total,
  output int   results_total
);

  logic [ubf_pkg::UID_W-1:0] uid_table [DEPTH];
  int unsigned               live_count = 0;
  bit                        filter_on = 1'b0;
  ubf_pkg::out_word_t        awaited [$];
  int                        fail_count = 0;
  int                        seen_count = 0;

  function automatic int find_slot(logic [ubf_pkg::UID_W-1:0] uid);
    int i;
    for (i = 0; i < live_count; i++)
      if (uid_table[i] == uid) return i;
    return -1;
  endfunction

  function automatic ubf_pkg::out_word_t apply_blocklist_cmd(ubf_pkg::in_word_t w);
    ubf_pkg::out_word_t r;
    int                 hit;
    int                 j;
    r = '0;
    case (w.cmd)
      ubf_pkg::CMD_PKT_CHECK: begin
        if (filter_on && w.has_owner && w.subject_uid != '0 &&
            find_slot(w.subject_uid) >= 0) begin
          r.blocked = 1'b1;
          if (w.protocol_kind == ubf_pkg::PROTO_IPV4) r.verdict = ubf_pkg::VERDICT_DROP_ICMP4;
          else if (w.protocol_kind == ubf_pkg::PROTO_IPV6)
            r.verdict = ubf_pkg::VERDICT_DROP_ICMP6;
          else r.verdict = ubf_pkg::VERDICT_DROP;
        end
      end
      ubf_pkg::CMD_PROC_CHECK: begin
        r.blocked = filter_on && find_slot(w.subject_uid) >= 0;
      end
      ubf_pkg::CMD_ADD: begin
        if (live_count >= DEPTH) begin
          r.status = ubf_pkg::STATUS_FULL;
        end else if (find_slot(w.subject_uid) < 0) begin
          uid_table[live_count] = w.subject_uid;
          live_count++;
        end
      end
      ubf_pkg::CMD_REMOVE: begin
        hit = find_slot(w.subject_uid);
        if (hit < 0) begin
          r.status = ubf_pkg::STATUS_NOT_FOUND;
        end else begin
          for (j = hit; j + 1 < live_count; j++) uid_table[j] = uid_table[j+1];
          live_count--;
        end
      end
      ubf_pkg::CMD_CLEAR: begin
        live_count = 0;
      end
      ubf_pkg::CMD_READ: begin
        if (w.read_index < live_count) r.entry_value = uid_table[w.read_index];
      end
      default: ;
    endcase
    r.entry_count = ubf_pkg::ENTRY_COUNT_W'(live_count);
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    $display("mismatch on result %0d, %s: got %h, expected %h", seen_count, what, got, want);
  endtask

  always @(posedge clk) begin
    ubf_pkg::out_word_t got;
    ubf_pkg::out_word_t want;
    if (!rst_n) begin
      live_count = 0;
      filter_on = 1'b0;
      awaited.delete();
    end else begin
      if (cfg_we) filter_on = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        seen_count++;
        if (awaited.size() == 0) begin
          flag_mismatch("word with none outstanding", 32'(got.entry_count), '0);
        end else begin
          want = awaited.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.blocked !== want.blocked)
            flag_mismatch("blocked", 32'(got.blocked), 32'(want.blocked));
          if (got.verdict !== want.verdict)
            flag_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
          if (got.entry_value !== want.entry_value)
            flag_mismatch("entry_value", got.entry_value, want.entry_value);
          if (got.entry_count !== want.entry_count)
            flag_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        end
      end
      if (in_ch.valid && in_ch.ready) awaited.push_back(apply_blocklist_cmd(in_ch.data));
    end
    fail_total <= fail_count;
    results_total <= seen_count;
  end

endmodule

// File: verif/testbench.sv
module testbench;

  localparam logic [ubf_pkg::CMD_W-1:0]   CMD_RSVD_6  = 3'd6;
  localparam logic [ubf_pkg::CMD_W-1:0]   CMD_RSVD_7  = 3'd7;
  localparam logic [ubf_pkg::PROTO_W-1:0] PROTO_OTHER = 2'd2;
  localparam logic [ubf_pkg::PROTO_W-1:0] PROTO_RSVD  = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  ubf_in_if  in_ch ();
  ubf_out_if out_ch ();

  int          fail_total;
  int          results_total;
  int          words_sent = 0;
  bit          calm = 1'b0;
  int          cmd_tally [8];
  logic [31:0] uid_pool [24];
  logic [31:0] fill_uids [256];

  uid_blocklist_filter_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  uid_blocklist_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_total    (fail_total),
    .results_total (results_total)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 26);
  end

  initial begin
    #15_000_000;
    $display("[uid_blocklist_filter_table] ERROR");
    $finish;
  end

  function automatic ubf_pkg::in_word_t make_word(logic [ubf_pkg::CMD_W-1:0] cmd,
                                                  logic [ubf_pkg::UID_W-1:0] uid,
                                                  logic owner,
                                                  logic [ubf_pkg::PROTO_W-1:0] proto,
                                                  logic [ubf_pkg::RIDX_W-1:0] idx);
    ubf_pkg::in_word_t w;
    w.cmd = cmd;
    w.subject_uid = uid;
    w.has_owner = owner;
    w.protocol_kind = proto;
    w.read_index = idx;
    return w;
  endfunction

  function automatic logic [ubf_pkg::UID_W-1:0] pick_uid();
    int slot;
    slot = $urandom_range(0, 23);
    if ($urandom_range(0, 99) < 20) uid_pool[slot] = $urandom;
    return uid_pool[slot];
  endfunction

  function automatic ubf_pkg::in_word_t random_word();
    int                         roll;
    logic [ubf_pkg::CMD_W-1:0]  cmd;
    logic [ubf_pkg::RIDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    if (roll < 28) cmd = ubf_pkg::CMD_PKT_CHECK;
    else if (roll < 44) cmd = ubf_pkg::CMD_PROC_CHECK;
    else if (roll < 68) cmd = ubf_pkg::CMD_ADD;
    else if (roll < 82) cmd = ubf_pkg::CMD_REMOVE;
    else if (roll < 94) cmd = ubf_pkg::CMD_READ;
    else if (roll < 96) cmd = ubf_pkg::CMD_CLEAR;
    else cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
    if ($urandom_range(0, 99) < 75) idx = ubf_pkg::RIDX_W'($urandom_range(0, 40));
    else idx = ubf_pkg::RIDX_W'($urandom_range(0, 255));
    return make_word(cmd, pick_uid(), $urandom_range(0, 99) < 80,
                     ubf_pkg::PROTO_W'($urandom_range(0, 3)), idx);
  endfunction

  task automatic push_word(ubf_pkg::in_word_t w);
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    cmd_tally[w.cmd]++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_total != words_sent);
  endtask

  task automatic set_filter(bit on);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (i = 0; i < 8; i++) cmd_tally[i] = 0;
    uid_pool[0] = '0;
    uid_pool[1] = '1;
    for (i = 2; i < 24; i++) uid_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, dup add, verdict per protocol, exemptions, shift on remove
    set_filter(1'b0);
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_REMOVE, 32'h0BAD_F00D, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_ADD, '1, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_ADD, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_ADD, 32'h1234_5678, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_ADD, 32'h1234_5678, 1'b1, ubf_pkg::PROTO_IPV6, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PKT_CHECK, '1, 1'b1, ubf_pkg::PROTO_IPV4, 8'd0));
    set_filter(1'b1);
    push_word(make_word(ubf_pkg::CMD_PKT_CHECK, '1, 1'b1, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PKT_CHECK, '1, 1'b1, ubf_pkg::PROTO_IPV6, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PKT_CHECK, '1, 1'b1, PROTO_OTHER, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PKT_CHECK, '1, 1'b1, PROTO_RSVD, 8'hff));
    push_word(make_word(ubf_pkg::CMD_PKT_CHECK, '1, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PKT_CHECK, '0, 1'b1, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PROC_CHECK, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PROC_CHECK, 32'h0BAD_F00D, 1'b1, ubf_pkg::PROTO_IPV6,
                        8'd0));
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd1));
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'hff));
    push_word(make_word(ubf_pkg::CMD_REMOVE, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_READ, '1, 1'b1, PROTO_RSVD, 8'd1));
    push_word(make_word(CMD_RSVD_6, '1, 1'b1, PROTO_RSVD, 8'hff));
    push_word(make_word(CMD_RSVD_7, 32'h1234_5678, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_CLEAR, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PROC_CHECK, 32'h1234_5678, 1'b0, ubf_pkg::PROTO_IPV4,
                        8'd0));

    // fill to full depth, then full-table corners
    set_filter(1'b1);
    push_word(make_word(ubf_pkg::CMD_CLEAR, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    for (i = 0; i < 256; i++) begin
      fill_uids[i] = {8'(i), 24'($urandom)};
      push_word(make_word(ubf_pkg::CMD_ADD, fill_uids[i], 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    end
    push_word(make_word(ubf_pkg::CMD_ADD, 32'h0BAD_F00D, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_ADD, fill_uids[5], 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'hff));
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PKT_CHECK, fill_uids[255], 1'b1, ubf_pkg::PROTO_IPV6,
                        8'd0));
    push_word(make_word(ubf_pkg::CMD_REMOVE, fill_uids[0], 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'hfe));
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'hff));
    push_word(make_word(ubf_pkg::CMD_ADD, '1, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_READ, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'hff));
    push_word(make_word(ubf_pkg::CMD_REMOVE, 32'h0BAD_F00D, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));
    push_word(make_word(ubf_pkg::CMD_PROC_CHECK, fill_uids[128], 1'b0, ubf_pkg::PROTO_IPV4,
                        8'd0));
    push_word(make_word(ubf_pkg::CMD_REMOVE, fill_uids[255], 1'b0, ubf_pkg::PROTO_IPV4,
                        8'd0));
    push_word(make_word(ubf_pkg::CMD_CLEAR, '0, 1'b0, ubf_pkg::PROTO_IPV4, 8'd0));

    for (i = 0; i < 4; i++) begin
      set_filter(i != 1);
      calm = (i == 3);
      repeat (220) push_word(random_word());
      settle();
    end
    calm = 1'b0;

    settle();
    repeat (800) @(posedge clk);
    $display("run covered %0d words: %0d packet checks, %0d process checks, %0d adds,",
             words_sent, cmd_tally[ubf_pkg::CMD_PKT_CHECK],
             cmd_tally[ubf_pkg::CMD_PROC_CHECK], cmd_tally[ubf_pkg::CMD_ADD]);
    $display("  %0d removes, %0d reads, %0d clears, %0d unused codes; filter on/off, full",
             cmd_tally[ubf_pkg::CMD_REMOVE], cmd_tally[ubf_pkg::CMD_READ],
             cmd_tally[ubf_pkg::CMD_CLEAR], cmd_tally[CMD_RSVD_6] + cmd_tally[CMD_RSVD_7]);
    if (fail_total == 0 && results_total == words_sent) begin
      $display("[uid_blocklist_filter_table] OK");
    end else begin
      $display("[uid_blocklist_filter_table] ERROR");
    end
    $finish;
  end

endmodule

// File: uid_blocklist_filter_table.f
rtl/core/ubf_pkg.sv
rtl/core/ubf_chan_if.sv
rtl/core/ubf_mem.sv
rtl/core/ubf_ctrl.sv
rtl/core/uid_blocklist_filter_table.sv
verif/uid_blocklist_checker.sv
verif/testbench.sv
